// ===== src/ppar_pkg.sv =====
`default_nettype none
package ppar_pkg;

    // Table geometry.
    localparam int PEER_SLOTS  = 16;
    localparam int WINDOW_BITS = 64;
    localparam int SLOT_W      = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
    localparam int GAP_W       = (WINDOW_BITS > 1) ? $clog2(WINDOW_BITS) : 1;

    // Hash constants.
    localparam logic [31:0] HASH_SEED  = 32'd5381;
    localparam int          HASH_SHIFT = 5;
    localparam int          ADDR_BYTES = 6;

    // Depth of the queues between the parts and at the result side.
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    typedef struct packed {
        logic [47:0] sender_address;
        logic [31:0] message_number;
    } ppar_in_t;

    typedef struct packed {
        logic accepted;
        logic slot_replaced;
    } ppar_out_t;

    // Classified item handed from the front to the back.
    typedef struct packed {
        ppar_in_t          item;
        logic [SLOT_W-1:0] slot;
    } ppar_job_t;

    // One table slot as stored in the RAM.
    typedef struct packed {
        logic [47:0]            address;
        logic [31:0]            highest;
        logic [WINDOW_BITS-1:0] window;
    } ppar_entry_t;

    localparam int ENTRY_W = $bits(ppar_entry_t);

    // Status of the back part, watched at the top level.
    typedef struct packed {
        logic               in_exec;
        logic [Q_CNT_W-1:0] out_count;
    } ppar_stat_t;

    // Six-step shift, add and xor hash over the address bytes, most
    // significant byte first, reduced to a slot index.
    function automatic logic [SLOT_W-1:0] slot_of(input logic [47:0] addr);
        logic [31:0] h;
        logic [31:0] b;
        h = HASH_SEED;
        for (int k = ADDR_BYTES - 1; k >= 0; k--) begin
            b = {24'd0, addr[k*8 +: 8]};
            h = ((h << HASH_SHIFT) + h) ^ b;
        end
        return SLOT_W'(h % 32'(PEER_SLOTS));
    endfunction

endpackage
`default_nettype wire

// ===== src/per_peer_anti_replay_window.sv =====
// Path: an accepted item waits in the front queue; its slot is read once the
// back is idle with room in the result queue, then the slot is rewritten.
// Rate: no new item is taken until the last one's rewrite is through, set by
// the read-then-write of the slot table through its single registered read port.
// Reset: asynchronous, clears queues, sequencer and slot valid bits at once;
// table contents are not swept, an invalid slot is always taken over.
`default_nettype none
module per_peer_anti_replay_window (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    output logic                     full,
    input  wire ppar_pkg::ppar_in_t  item,
    output logic                     empty,
    input  wire logic                pop,
    output ppar_pkg::ppar_out_t      verdict
);
    import ppar_pkg::*;

    ppar_job_t  job;
    logic       job_valid;
    logic       job_take;
    ppar_stat_t stat;

    // Accept and classify.
    ppar_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .job       (job),
        .job_valid (job_valid),
        .job_take  (job_take)
    );

    // Table update and result queue.
    ppar_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (job),
        .job_valid (job_valid),
        .job_take  (job_take),
        .empty     (empty),
        .pop       (pop),
        .verdict   (verdict),
        .stat      (stat)
    );

    // A slot rewrite is always followed by a return to idle in the next cycle.
    a_exec_single: assert property (@(posedge clk) disable iff (!rst_n)
        stat.in_exec |=> !stat.in_exec)
        else $error("slot rewrite lasted more than one cycle");

    // A taken item is carried out in the next cycle.
    a_take_exec: assert property (@(posedge clk) disable iff (!rst_n)
        job_take |=> stat.in_exec)
        else $error("taken item not carried out");

    // No item is taken while a rewrite is in progress.
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        stat.in_exec |-> !job_take)
        else $error("item taken during rewrite");

    // The result queue never overflows.
    a_out_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stat.out_count <= Q_CNT_W'(Q_DEPTH))
        else $error("result queue overflow");

endmodule
`default_nettype wire

// ===== src/ppar_ram.sv =====
`default_nettype none
module ppar_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== src/ppar_front.sv =====
`default_nettype none
module ppar_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire ppar_pkg::ppar_in_t item,
    output ppar_pkg::ppar_job_t     job,
    output logic                    job_valid,
    input  wire logic               job_take
);
    import ppar_pkg::*;

    ppar_job_t          q_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;
    logic               do_push;
    logic               do_pop;
    ppar_job_t          new_job;

    assign full      = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign job_valid = (count_reg != '0);
    assign job       = q_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = job_take && job_valid;

    // Classify the incoming item by its table slot.
    always_comb
    begin
        new_job.item = item;
        new_job.slot = slot_of(item.sender_address);
    end

    // Queue pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + Q_CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - Q_CNT_W'(1);
            end
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= new_job;
        end
    end

endmodule
`default_nettype wire

// ===== src/ppar_back.sv =====
`default_nettype none
module ppar_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire ppar_pkg::ppar_job_t job,
    input  wire logic                job_valid,
    output logic                     job_take,
    output logic                     empty,
    input  wire logic                pop,
    output ppar_pkg::ppar_out_t      verdict,
    output ppar_pkg::ppar_stat_t     stat
);
    import ppar_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t             state_reg;
    ppar_job_t          cur_reg;
    logic [PEER_SLOTS-1:0] valid_reg;

    ppar_entry_t        rd_entry;
    ppar_entry_t        wr_entry;
    logic [ENTRY_W-1:0] rd_data;
    logic               wr_en;
    ppar_out_t          res;

    logic [31:0]        gap_up;
    logic [31:0]        gap_down;
    logic [GAP_W-1:0]   down_idx;
    logic               hit;

    ppar_out_t          oq_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] owr_ptr_reg;
    logic [Q_PTR_W-1:0] ord_ptr_reg;
    logic [Q_CNT_W-1:0] ocount_reg;
    logic               out_pop;

    // Slot table.
    ppar_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (PEER_SLOTS)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (cur_reg.slot),
        .wr_data (wr_entry),
        .rd_en   (job_take),
        .rd_addr (job.slot),
        .rd_data (rd_data)
    );

    assign rd_entry = rd_data;
    assign job_take = (state_reg == ST_IDLE) && job_valid
                      && (ocount_reg != Q_CNT_W'(Q_DEPTH));
    assign wr_en    = (state_reg == ST_EXEC);

    // Window update for the item whose slot has just been read.
    always_comb
    begin
        hit      = valid_reg[cur_reg.slot]
                   && (rd_entry.address == cur_reg.item.sender_address);
        gap_up   = cur_reg.item.message_number - rd_entry.highest;
        gap_down = rd_entry.highest - cur_reg.item.message_number;
        down_idx = gap_down[GAP_W-1:0];
        wr_entry = rd_entry;
        res.accepted      = 1'b0;
        res.slot_replaced = 1'b0;
        if (!hit)
        begin
            // Empty slot or another sender: take the slot over.
            wr_entry.address  = cur_reg.item.sender_address;
            wr_entry.highest  = cur_reg.item.message_number;
            wr_entry.window   = WINDOW_BITS'(1);
            res.accepted      = 1'b1;
            res.slot_replaced = 1'b1;
        end
        else if (cur_reg.item.message_number > rd_entry.highest)
        begin
            // Newer number: slide the window or restart it.
            if (gap_up < 32'(WINDOW_BITS))
            begin
                wr_entry.window = (rd_entry.window << gap_up) | WINDOW_BITS'(1);
            end
            else
            begin
                wr_entry.window = WINDOW_BITS'(1);
            end
            wr_entry.highest = cur_reg.item.message_number;
            res.accepted     = 1'b1;
        end
        else if ((gap_down < 32'(WINDOW_BITS)) && !rd_entry.window[down_idx])
        begin
            // Older number inside the window and not seen yet.
            wr_entry.window[down_idx] = 1'b1;
            res.accepted              = 1'b1;
        end
    end

    // Sequencer and slot valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (job_take)
                    begin
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC:
                begin
                    valid_reg[cur_reg.slot] <= 1'b1;
                    state_reg               <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Item held while its slot is read and rewritten.
    always_ff @(posedge clk)
    begin
        if (job_take)
        begin
            cur_reg <= job;
        end
    end

    // Result queue control.
    assign empty   = (ocount_reg == '0);
    assign verdict = oq_reg[ord_ptr_reg];
    assign out_pop = pop && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owr_ptr_reg <= '0;
            ord_ptr_reg <= '0;
            ocount_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                owr_ptr_reg <= owr_ptr_reg + Q_PTR_W'(1);
            end
            if (out_pop)
            begin
                ord_ptr_reg <= ord_ptr_reg + Q_PTR_W'(1);
            end
            if (wr_en && !out_pop)
            begin
                ocount_reg <= ocount_reg + Q_CNT_W'(1);
            end
            else if (out_pop && !wr_en)
            begin
                ocount_reg <= ocount_reg - Q_CNT_W'(1);
            end
        end
    end

    // Result queue storage.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            oq_reg[owr_ptr_reg] <= res;
        end
    end

    assign stat.in_exec   = (state_reg == ST_EXEC);
    assign stat.out_count = ocount_reg;

endmodule
`default_nettype wire
